// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and address helper for the text console writer.
package tcw_pkg;

   localparam int unsigned SCREEN_COLS = 80;
   localparam int unsigned SCREEN_ROWS = 25;
   localparam int unsigned CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

   localparam int unsigned ADDR_W = 11;
   localparam int unsigned COL_W  = 7;
   localparam int unsigned ROW_W  = 5;
   localparam int unsigned CELL_W = 16;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_NULL      = 8'h00;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_MARKER    = 8'h7C;
   localparam logic [7:0] TAB_STEP     = 8'd4;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [CELL_W-1:0] read_data;
      logic              screen_cleared;
   } rsp_type;

   // Linear cell index of a row and column; one bit wider than an address so
   // that the cell just past the screen can be recognised.
   function automatic logic [ADDR_W:0] cell_index(input logic [ROW_W:0] row,
                                                  input logic [COL_W:0] col);
      logic [ADDR_W:0] prod;
      prod = (ADDR_W+1)'(row) * (ADDR_W+1)'(SCREEN_COLS);
      return prod + (ADDR_W+1)'(col);
   endfunction

endpackage

// ===== hw/rtl/text_console_writer_core.sv =====
// Top level of the text console writer: cursor logic and the screen memory.
//
// An item is taken at a clock edge where start is high and busy is low. Each
// item gives exactly one result beat on rsp_data, marked by rsp_strobe for a
// single cycle; the receiver has no way to hold it off.
// A read issues the memory read as the item is taken, and the beat follows
// in the cycle after the data returns. A put of a zero byte gives its beat
// in the next cycle. A put that does not overflow the screen costs one
// read-modify-write of the written cell and one of the marker cell through
// the separate read and write ports of the screen memory, in ST_WR and then
// ST_MARK, which registers the beat. A tab or newline skips the first cell update.
// A put that runs off the last row sweeps all 2000 cells, one cell per cycle
// with the read of each cell overlapping the write of the previous one, with
// busy high throughout; a character written first goes through ST_WR before the sweep.
// After reset the block zeroes the screen memory, one cell per cycle, with
// busy high; the cursor sits at row 0, column 0.
module text_console_writer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_INIT = 6'b000001,
      ST_IDLE = 6'b000010,
      ST_RD   = 6'b000100,
      ST_WR   = 6'b001000,
      ST_CLR  = 6'b010000,
      ST_MARK = 6'b100000
   } state_type;

   localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
      tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
   localparam logic [tcw_pkg::ADDR_W-1:0] CELLS = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT);

   logic [tcw_pkg::CELL_W-1:0] screen_mem [tcw_pkg::CELL_COUNT];

   state_type                    state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]    cursor_col_ff, cursor_col_in;
   logic [tcw_pkg::ROW_W-1:0]    cursor_row_ff, cursor_row_in;
   logic [tcw_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic                         clr_wr_ff, clr_wr_in;
   logic [tcw_pkg::ADDR_W-1:0]   clr_wa_ff, clr_wa_in;
   logic [tcw_pkg::ADDR_W-1:0]   first_addr_ff, first_addr_in;
   logic [7:0]                   first_char_ff, first_char_in;
   logic [tcw_pkg::ADDR_W-1:0]   mark_addr_ff, mark_addr_in;
   logic                         cleared_ff, cleared_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic [tcw_pkg::CELL_W-1:0]   rdata_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   tcw_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         mem_re;
   logic [tcw_pkg::ADDR_W-1:0]   mem_ra;
   logic                         mem_we;
   logic [tcw_pkg::ADDR_W-1:0]   mem_wa;
   logic [tcw_pkg::CELL_W-1:0]   mem_wd;

   // Cursor arithmetic for a put, worked out from the current cursor.
   logic [tcw_pkg::COL_W:0]      x1, x2, x3;
   logic [tcw_pkg::ROW_W:0]      y1, y2, y3;
   logic [tcw_pkg::ADDR_W:0]     first_idx;
   logic                         first_ok;
   logic                         ovf;
   logic [tcw_pkg::ADDR_W:0]     mark_idx;

   always_comb begin
      x1        = {1'b0, cursor_col_ff};
      y1        = {1'b0, cursor_row_ff};
      first_idx = tcw_pkg::cell_index(y1, x1);
      first_ok  = 1'b0;
      if (req_data.char_code == tcw_pkg::CH_BACKSPACE) begin
         if (x1 == '0 && y1 != '0) begin
            y1 = y1 - 1'b1;
            x1 = (tcw_pkg::COL_W+1)'(tcw_pkg::SCREEN_COLS - 1);
         end else if (x1 != '0) begin
            x1 = x1 - 1'b1;
         end
         first_idx = tcw_pkg::cell_index(y1, x1) + 1'b1;
         first_ok  = first_idx < (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELL_COUNT);
      end else if (req_data.char_code == tcw_pkg::CH_TAB) begin
         x1 = x1 + tcw_pkg::TAB_STEP;
      end else if (req_data.char_code == tcw_pkg::CH_NEWLINE) begin
         x1 = '0;
         y1 = y1 + 1'b1;
      end else begin
         first_ok = 1'b1;
         x1       = x1 + 1'b1;
      end
      if (x1 >= (tcw_pkg::COL_W+1)'(tcw_pkg::SCREEN_COLS)) begin
         x2 = '0;
         y2 = y1 + 1'b1;
      end else begin
         x2 = x1;
         y2 = y1;
      end
      ovf      = y2 >= (tcw_pkg::ROW_W+1)'(tcw_pkg::SCREEN_ROWS);
      x3       = ovf ? '0 : x2;
      y3       = ovf ? '0 : y2;
      mark_idx = tcw_pkg::cell_index(y3, x3);
   end

   always_comb begin
      state_in      = state_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      clr_in        = clr_ff;
      clr_wr_in     = clr_wr_ff;
      clr_wa_in     = clr_wa_ff;
      first_addr_in = first_addr_ff;
      first_char_in = first_char_ff;
      mark_addr_in  = mark_addr_ff;
      cleared_in    = cleared_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_re        = 1'b0;
      mem_ra        = mark_addr_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_wa_ff;
      mem_wd        = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.opcode == tcw_pkg::OP_READ) begin
                  rd_ok_in = req_data.cell_address < CELLS;
                  mem_re   = rd_ok_in;
                  mem_ra   = req_data.cell_address;
                  state_in = ST_RD;
               end else if (req_data.char_code == tcw_pkg::CH_NULL) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_in.cursor_col     = cursor_col_ff;
                  rsp_in.cursor_row     = cursor_row_ff;
                  rsp_in.read_data      = '0;
                  rsp_in.screen_cleared = 1'b0;
               end else begin
                  cursor_col_in = tcw_pkg::COL_W'(x3);
                  cursor_row_in = tcw_pkg::ROW_W'(y3);
                  cleared_in    = ovf;
                  mark_addr_in  = tcw_pkg::ADDR_W'(mark_idx);
                  first_addr_in = tcw_pkg::ADDR_W'(first_idx);
                  first_char_in = (req_data.char_code == tcw_pkg::CH_BACKSPACE) ?
                                  tcw_pkg::CH_SPACE : req_data.char_code;
                  clr_in        = '0;
                  clr_wr_in     = 1'b0;
                  if (first_ok) begin
                     mem_re   = 1'b1;
                     mem_ra   = tcw_pkg::ADDR_W'(first_idx);
                     state_in = ST_WR;
                  end else if (ovf) begin
                     state_in = ST_CLR;
                  end else begin
                     mem_re   = 1'b1;
                     mem_ra   = tcw_pkg::ADDR_W'(mark_idx);
                     state_in = ST_MARK;
                  end
               end
            end
         end
         ST_RD: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.cursor_col     = cursor_col_ff;
            rsp_in.cursor_row     = cursor_row_ff;
            rsp_in.read_data      = rd_ok_ff ? rdata_ff : '0;
            rsp_in.screen_cleared = 1'b0;
            state_in              = ST_IDLE;
         end
         ST_WR: begin
            // The marker cell never coincides with the cell written here.
            mem_we = 1'b1;
            mem_wa = first_addr_ff;
            mem_wd = {rdata_ff[15:8], first_char_ff};
            if (cleared_ff) begin
               state_in = ST_CLR;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = mark_addr_ff;
               state_in = ST_MARK;
            end
         end
         ST_CLR: begin
            // Read cell n while writing back cell n-1 with a space.
            if (clr_wr_ff) begin
               mem_we = 1'b1;
               mem_wa = clr_wa_ff;
               mem_wd = {rdata_ff[15:8], tcw_pkg::CH_SPACE};
            end
            if (clr_ff != CELLS) begin
               mem_re    = 1'b1;
               mem_ra    = clr_ff;
               clr_wa_in = clr_ff;
               clr_wr_in = 1'b1;
               clr_in    = clr_ff + 1'b1;
            end else begin
               // Home cell was swept long ago, so its marker read may start now.
               clr_wr_in = 1'b0;
               mem_re    = 1'b1;
               mem_ra    = mark_addr_ff;
               state_in  = ST_MARK;
            end
         end
         ST_MARK: begin
            mem_we                = 1'b1;
            mem_wa                = mark_addr_ff;
            mem_wd                = {rdata_ff[15:8], tcw_pkg::CH_MARKER};
            rsp_strobe_in         = 1'b1;
            rsp_in.cursor_col     = cursor_col_ff;
            rsp_in.cursor_row     = cursor_row_ff;
            rsp_in.read_data      = '0;
            rsp_in.screen_cleared = cleared_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         clr_ff        <= '0;
         clr_wr_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         clr_ff        <= clr_in;
         clr_wr_ff     <= clr_wr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_wa_ff     <= clr_wa_in;
      first_addr_ff <= first_addr_in;
      first_char_ff <= first_char_in;
      mark_addr_ff  <= mark_addr_in;
      cleared_ff    <= cleared_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the text console writer: shadow screen, random traffic, checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   // Shadow copy of the console: screen cells, cursor and the replies still owed.
   class console_board;
      logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
      int unsigned       shadow_col;
      int unsigned       shadow_row;
      rsp_type           pending_replies [$];
      int unsigned       errors;
      int unsigned       beats;
      int unsigned       puts;
      int unsigned       reads;
      int unsigned       clears;

      function new();
         foreach (shadow_screen[i]) shadow_screen[i] = '0;
         shadow_col = 0;
         shadow_row = 0;
         errors     = 0;
         beats      = 0;
         puts       = 0;
         reads      = 0;
         clears     = 0;
      endfunction

      // Replace the character byte of a cell, keeping its attribute.
      function void put_char(int unsigned index, logic [7:0] ch);
         if (index < CELL_COUNT) shadow_screen[index] = {shadow_screen[index][15:8], ch};
      endfunction

      function void take_item(req_type item);
         rsp_type     reply;
         int unsigned x;
         int unsigned y;
         int unsigned i;
         reply = '0;
         if (item.opcode == OP_READ) begin
            reads++;
            if (item.cell_address < CELL_COUNT)
               reply.read_data = shadow_screen[item.cell_address];
         end else if (item.char_code != CH_NULL) begin
            puts++;
            x = shadow_col;
            y = shadow_row;
            case (item.char_code)
               CH_BACKSPACE: begin
                  if (x == 0 && y != 0) begin
                     y--;
                     x = SCREEN_COLS - 1;
                  end else if (x != 0) begin
                     x--;
                  end
                  // The blanked cell is the one after the new cursor, which may lie
                  // on the next row or just past the screen.
                  put_char(y * SCREEN_COLS + x + 1, CH_SPACE);
               end
               CH_TAB: x += TAB_STEP;
               CH_NEWLINE: begin
                  x = 0;
                  y++;
               end
               default: begin
                  put_char(y * SCREEN_COLS + x, item.char_code);
                  x++;
               end
            endcase
            if (x >= SCREEN_COLS) begin
               y++;
               x = 0;
            end
            if (y >= SCREEN_ROWS) begin
               for (i = 0; i < CELL_COUNT; i++) put_char(i, CH_SPACE);
               x = 0;
               y = 0;
               reply.screen_cleared = 1'b1;
               clears++;
            end
            put_char(y * SCREEN_COLS + x, CH_MARKER);
            shadow_col = x;
            shadow_row = y;
         end
         reply.cursor_col = COL_W'(shadow_col);
         reply.cursor_row = ROW_W'(shadow_row);
         pending_replies.push_back(reply);
      endfunction

      task report_mismatch(string what);
         if (errors < 40) $display("[%0t] mismatch on beat %0d: %s", $realtime, beats, what);
         errors++;
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         beats++;
         if (pending_replies.size() == 0) begin
            report_mismatch("result beat with no item outstanding");
            return;
         end
         want = pending_replies.pop_front();
         if (got.cursor_col !== want.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                      got.cursor_col, want.cursor_col));
         if (got.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                      got.cursor_row, want.cursor_row));
         if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      got.read_data, want.read_data));
         if (got.screen_cleared !== want.screen_cleared)
            report_mismatch($sformatf("screen_cleared %b, expected %b",
                                      got.screen_cleared, want.screen_cleared));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   console_board board = new();
   int unsigned  burst_left = 0;

   text_console_writer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_reply(rsp_data);
   end

   // Holds start high until the item is taken, then decides whether the burst goes on.
   task automatic issue_item(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.take_item(item);
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_put(input logic [7:0] ch);
      req_type item;
      item.opcode       = OP_PUT;
      item.char_code    = ch;
      item.cell_address = ADDR_W'($urandom());
      issue_item(item);
   endtask

   task automatic send_read(input logic [ADDR_W-1:0] addr);
      req_type item;
      item.opcode       = OP_READ;
      item.char_code    = 8'($urandom());
      item.cell_address = addr;
      issue_item(item);
   endtask

   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0:       b = 8'($urandom_range(128, 255));
         1:       b = 8'($urandom_range(1, 31));
         default: b = 8'($urandom_range(32, 127));
      endcase
      if (b == CH_BACKSPACE || b == CH_TAB || b == CH_NEWLINE) b = CH_SPACE;
      return b;
   endfunction

   // Mostly runs of text broken by control bytes, with newline bursts to run off the
   // bottom row, plus reads both around the cursor and anywhere in the address range.
   task automatic run_random_text(input int unsigned target);
      int unsigned sent;
      int unsigned run_len;
      int unsigned pick;
      int          near;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         run_len = 1;
         if (pick < 36) begin
            run_len = $urandom_range(1, 16);
            repeat (run_len) send_put(pick_text_byte());
         end else if (pick < 50) begin
            send_put(CH_NEWLINE);
         end else if (pick < 56) begin
            run_len = $urandom_range(5, 26);
            repeat (run_len) send_put(CH_NEWLINE);
         end else if (pick < 63) begin
            run_len = $urandom_range(1, 4);
            repeat (run_len) send_put(CH_TAB);
         end else if (pick < 70) begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) send_put(CH_BACKSPACE);
         end else if (pick < 73) begin
            // The block leaves screen and cursor alone for a zero byte, so it does not count towards the total.
            send_put(CH_NULL);
            run_len = 0;
         end else if (pick < 90) begin
            run_len = $urandom_range(1, 4);
            repeat (run_len) begin
               near = int'(board.shadow_row * SCREEN_COLS + board.shadow_col)
                      - int'($urandom_range(0, 40)) + 1;
               if (near < 0) near = 0;
               send_read(ADDR_W'(near));
            end
         end else begin
            run_len = $urandom_range(1, 3);
            repeat (run_len) send_read(ADDR_W'($urandom_range(0, 2047)));
         end
         sent += run_len;
      end
   endtask

   initial begin
      int unsigned waited;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: address extremes, backspace at home and across a row,
      // tab, newline, zero and high bytes, and a column wrap from the last column.
      send_read('0);
      send_read(ADDR_W'(CELL_COUNT - 1));
      send_read(ADDR_W'(CELL_COUNT));
      send_read('1);
      send_put(CH_BACKSPACE);
      send_read(ADDR_W'(1));
      send_read('0);
      send_put(8'h41);
      send_put(CH_NULL);
      send_put(8'hFF);
      send_put(8'h80);
      send_put(CH_TAB);
      send_put(CH_NEWLINE);
      send_put(CH_BACKSPACE);
      send_read(ADDR_W'(SCREEN_COLS));
      send_read(ADDR_W'(SCREEN_COLS - 1));
      send_put(8'h5A);
      send_put(8'h01);
      send_put(8'h7F);
      send_read(ADDR_W'(SCREEN_COLS - 1));
      send_read(ADDR_W'(SCREEN_COLS + 1));

      run_random_text(780);

      start <= 1'b0;
      waited = 0;
      while (board.pending_replies.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (board.pending_replies.size() != 0)
         board.report_mismatch($sformatf("%0d results never arrived",
                                         board.pending_replies.size()));

      $display("Covered %0d character puts, %0d of them clearing the screen, and %0d cell reads;",
               board.puts, board.clears, board.reads);
      $display("%0d result beats compared, %0d mismatches.", board.beats, board.errors);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
